FILE: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, muted while reset is asserted.
`define CPT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cpt port check failed");

// Next-cycle implication built on the one above.
`define CPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    `CPT_ASSERT(label, clk, rstn, (ante) |=> (cons))

`endif

FILE: design/cpt_pkg.sv
package cpt_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MIN_VERTICES     = 3;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_CLOSED_FLAG  = 1'b1;

    // sign of one cross product, flagged valid
    typedef struct packed {
        logic vld;
        logic neg;
        logic pos;
    } cpt_sign_t;

endpackage

FILE: design/convex_polygon_point_test_core.sv
// Point-in-convex-polygon test core.
// Input channel (s_valid/s_ready): one item per operation. Clear empties the
// bounding box, load writes vertex s_vertex_index and widens the box, query
// tests point (s_x_coord, s_y_coord). Clear and load give no result; s_ready
// stays high after them.
// Result channel (m_valid/m_ready): one item, m_inside_res, per query.
// A query that fails the closure, vertex-count or box check goes straight to
// the finish state and answers 0. Otherwise it walks the ring: n+1 vertex reads
// (n = vertex_count, capped at MAX_VERTICES) feed one shared cross-product
// unit, one product per cycle; the single read port of the vertex RAM sets
// that pace.
// s_ready is low while a query runs. A finished result sits in the output
// register; if the receiver stalls, the core holds the next query result and
// stays busy until the output register frees, while loads and clears are
// still taken next to a waiting result.
// APB port: vertex_count at 0x0, closed_flag at 0x4, pready always high.
// Reset (aresetn low, synchronous) clears the box, both registers, the
// sequencer and the output valid; vertex slots are undefined until loaded.
module convex_polygon_point_test_core #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpt_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cpt_pkg::OP_W-1:0]      s_operation,
    input  logic [cpt_pkg::INDEX_W-1:0]   s_vertex_index,
    input  logic signed [COORD_BITS-1:0]  s_x_coord,
    input  logic signed [COORD_BITS-1:0]  s_y_coord,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_inside_res,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpt_pkg::PADDR_W-1:0]   paddr,
    input  logic [cpt_pkg::PDATA_W-1:0]   pwdata,
    output logic [cpt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import cpt_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int NW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int XW    = INDEX_W + AW;
    localparam int DW    = COORD_BITS + 1;

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    function automatic logic opposite(input cpt_sign_t a, input cpt_sign_t b);
        return (a.neg && b.pos) || (a.pos && b.neg);
    endfunction

    // config registers
    logic [COUNT_W-1:0] vertex_count_reg;
    logic               closed_flag_reg;

    // box
    logic signed [COORD_BITS-1:0] box_min_x_reg, box_max_x_reg;
    logic signed [COORD_BITS-1:0] box_min_y_reg, box_max_y_reg;
    logic                         box_valid_reg;

    // sequencer
    state_t             state_reg;
    logic               m_valid_reg, m_inside_reg;
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic               iss_done_reg;
    logic               rd_vld_reg, rd_first_reg;
    logic               pair_vld_reg;
    logic [CNT_W-1:0]   res_cnt_reg;
    logic               fail_reg;
    logic               res_reg;

    // payload
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [CNT_W-1:0]             n_reg;
    logic signed [DW-1:0]         cur_dx_reg, cur_dy_reg, prev_dx_reg, prev_dy_reg;
    cpt_sign_t                    first_sign_reg, prev_sign_reg;

    logic                         s_acc, load_ok, reject;
    logic [XW-1:0]                idx_ext;
    logic [NW-1:0]                vc_ext;
    logic [CNT_W-1:0]             n_next;
    logic                         issue_en;
    logic [AW-1:0]                raddr;
    logic [2*COORD_BITS-1:0]      rdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [DW-1:0]         dx_next, dy_next;
    cpt_sign_t                    sgn;
    logic                         last_res, fail_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_acc        = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;
    assign pready       = 1'b1;

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
            closed_flag_reg  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[COUNT_W-1:0];
                REG_CLOSED_FLAG:  closed_flag_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count_reg);
            REG_CLOSED_FLAG:  prdata = PDATA_W'(closed_flag_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- load path and box ----------------
    assign idx_ext = XW'(s_vertex_index);
    assign load_ok = s_acc && (s_operation == OP_LOAD) && (idx_ext < XW'(MAX_VERTICES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_min_x_reg <= CMAX;
            box_min_y_reg <= CMAX;
            box_max_x_reg <= CMIN;
            box_max_y_reg <= CMIN;
            box_valid_reg <= 1'b0;
        end else if (s_acc && (s_operation == OP_CLEAR)) begin
            box_min_x_reg <= CMAX;
            box_min_y_reg <= CMAX;
            box_max_x_reg <= CMIN;
            box_max_y_reg <= CMIN;
            box_valid_reg <= 1'b0;
        end else if (load_ok) begin
            if (s_x_coord < box_min_x_reg) box_min_x_reg <= s_x_coord;
            if (s_x_coord > box_max_x_reg) box_max_x_reg <= s_x_coord;
            if (s_y_coord < box_min_y_reg) box_min_y_reg <= s_y_coord;
            if (s_y_coord > box_max_y_reg) box_max_y_reg <= s_y_coord;
            box_valid_reg <= 1'b1;
        end
    end

    // vertex store, x in the upper half
    cpt_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(MAX_VERTICES)
    ) u_store (
        .aclk (aclk),
        .we   (load_ok),
        .waddr(idx_ext[AW-1:0]),
        .wdata({s_x_coord, s_y_coord}),
        .raddr(raddr),
        .rdata(rdata)
    );

    // ---------------- query setup ----------------
    assign vc_ext = NW'(vertex_count_reg);
    assign n_next = (vc_ext > NW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_ext[CNT_W-1:0];

    assign reject = !closed_flag_reg || (n_next < CNT_W'(MIN_VERTICES)) || !box_valid_reg ||
                    (s_x_coord < box_min_x_reg) || (s_x_coord > box_max_x_reg) ||
                    (s_y_coord < box_min_y_reg) || (s_y_coord > box_max_y_reg);

    // ---------------- ring walk ----------------
    // reads 0..n-1 then 0 again to close the ring
    assign issue_en = (state_reg == ST_WALK) && !iss_done_reg;
    assign raddr    = (iss_cnt_reg == n_reg) ? '0 : iss_cnt_reg[AW-1:0];

    assign rd_x    = rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_y    = rdata[COORD_BITS-1:0];
    assign dx_next = {rd_x[COORD_BITS-1], rd_x} - {px_reg[COORD_BITS-1], px_reg};
    assign dy_next = {rd_y[COORD_BITS-1], rd_y} - {py_reg[COORD_BITS-1], py_reg};

    cpt_cross_unit #(
        .DW(DW)
    ) u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (pair_vld_reg),
        .ax      (prev_dx_reg),
        .ay      (prev_dy_reg),
        .bx      (cur_dx_reg),
        .by      (cur_dy_reg),
        .sign_out(sgn)
    );

    assign last_res  = (res_cnt_reg == n_reg - CNT_W'(1));
    assign fail_next = fail_reg ||
                       ((res_cnt_reg != '0) && opposite(prev_sign_reg, sgn)) ||
                       (last_res && opposite(sgn, first_sign_reg));

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            m_inside_reg <= 1'b0;
            iss_done_reg <= 1'b0;
            iss_cnt_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            pair_vld_reg <= 1'b0;
            res_cnt_reg  <= '0;
            fail_reg     <= 1'b0;
            res_reg      <= 1'b0;
        end else begin
            // in ST_FINISH the output register is handled below
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            rd_vld_reg   <= issue_en;
            rd_first_reg <= issue_en && (iss_cnt_reg == '0);
            pair_vld_reg <= rd_vld_reg && !rd_first_reg;

            if (issue_en) begin
                if (iss_cnt_reg == n_reg) begin
                    iss_done_reg <= 1'b1;
                end else begin
                    iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && (s_operation == OP_QUERY)) begin
                        iss_cnt_reg  <= '0;
                        iss_done_reg <= 1'b0;
                        res_cnt_reg  <= '0;
                        fail_reg     <= 1'b0;
                        if (reject) begin
                            res_reg   <= 1'b0;
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (sgn.vld) begin
                        fail_reg    <= fail_next;
                        res_cnt_reg <= res_cnt_reg + CNT_W'(1);
                        if (last_res) begin
                            res_reg   <= !fail_next;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_inside_reg <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc && (s_operation == OP_QUERY)) begin
            px_reg <= s_x_coord;
            py_reg <= s_y_coord;
            n_reg  <= n_next;
        end
        if (rd_vld_reg) begin
            cur_dx_reg  <= dx_next;
            cur_dy_reg  <= dy_next;
            prev_dx_reg <= cur_dx_reg;
            prev_dy_reg <= cur_dy_reg;
        end
        if (sgn.vld) begin
            prev_sign_reg <= sgn;
            if (res_cnt_reg == '0) begin
                first_sign_reg <= sgn;
            end
        end
    end

endmodule

FILE: design/cpt_ram.sv
module cpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: design/cpt_cross_unit.sv
// Two-stage cross product: products, then difference and sign.
module cpt_cross_unit #(
    parameter int DW = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_vld,
    input  logic signed [DW-1:0] ax,
    input  logic signed [DW-1:0] ay,
    input  logic signed [DW-1:0] bx,
    input  logic signed [DW-1:0] by,
    output cpt_pkg::cpt_sign_t   sign_out
);
    import cpt_pkg::*;

    localparam int PW = 2 * DW;

    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 vld1_reg;
    logic signed [PW:0]   diff;
    logic                 vld2_reg, neg_reg, pos_reg;

    assign diff = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg  <= ax * by;
        p2_reg  <= ay * bx;
        neg_reg <= diff[PW];
        pos_reg <= !diff[PW] && (diff != '0);
    end

    assign sign_out = '{vld: vld2_reg, neg: neg_reg, pos: pos_reg};

endmodule

FILE: design/cpt_checker.sv
// Port-level checks for the polygon test core.
`include "assert_macros.svh"

module cpt_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [cpt_pkg::OP_W-1:0] s_operation,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_inside_res
);
    import cpt_pkg::*;

    // stalled result holds
    `CPT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_inside_res))

    // a query makes the core busy
    `CPT_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && (s_operation == OP_QUERY), !s_ready)

    // clear, load and unused codes leave the core ready in the next cycle
    `CPT_ASSERT_NEXT(a_other_quick, aclk, aresetn, s_valid && s_ready && (s_operation != OP_QUERY), s_ready)

    // a result appears only at the end of a busy period
    `CPT_ASSERT(a_res_from_busy, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready))

endmodule

bind convex_polygon_point_test_core cpt_checker u_cpt_checker (.*);

FILE: sim/tb_convex_polygon_point_test_core.sv
`timescale 1ns / 1ps

module tb_convex_polygon_point_test_core;
    import cpt_pkg::*;

    localparam int  CW             = COORD_BITS_DEF;
    localparam int  RING           = MAX_VERTICES_DEF;
    localparam int  MAX_WAIT       = 18;
    // cycles to let a query run out once nothing is expected
    localparam int  SETTLE_CYCLES  = 40;
    // cycles without any handshake before the run is declared hung
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam real PI             = 3.14159265358979;

    // operation code the core must ignore
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    localparam logic signed [CW-1:0] COORD_TOP    = 16'sh7FFF;
    localparam logic signed [CW-1:0] COORD_BOTTOM = 16'sh8000;

    // one input item plus the idling mode of the sequence it belongs to
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] slot;
        logic [CW-1:0]      x;
        logic [CW-1:0]      y;
        logic               s_quiet;
        logic               m_quiet;
    } poly_item_t;

    // ------------------------------------------------------------------
    // DUT connections, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation    = OP_CLEAR;
    logic [INDEX_W-1:0]    s_vertex_index = '0;
    logic signed [CW-1:0]  s_x_coord      = '0;
    logic signed [CW-1:0]  s_y_coord      = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_inside_res;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [PADDR_W-1:0]    paddr          = '0;
    logic [PDATA_W-1:0]    pwdata         = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    convex_polygon_point_test_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_vertex_index (s_vertex_index),
        .s_x_coord      (s_x_coord),
        .s_y_coord      (s_y_coord),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Polygon predictor: its own copy of the vertex store, bounding box
    // and registers, advanced at every accepted item and register write.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] ring_x [RING];
    logic signed [CW-1:0] ring_y [RING];
    logic signed [CW-1:0] box_lo_x = COORD_TOP;
    logic signed [CW-1:0] box_hi_x = COORD_BOTTOM;
    logic signed [CW-1:0] box_lo_y = COORD_TOP;
    logic signed [CW-1:0] box_hi_y = COORD_BOTTOM;
    bit                   box_set  = 1'b0;
    logic [COUNT_W-1:0]   cfg_count  = '0;
    bit                   cfg_closed = 1'b0;

    // expected inside_res values, oldest first
    bit inside_expected [$];

    // exact cross product of (a - p) and (b - p); 35 bits fit easily in 64
    function automatic longint ring_cross(int a, int b, longint px, longint py);
        longint ax, ay, bx, by;
        ax = ring_x[a];
        ay = ring_y[a];
        bx = ring_x[b];
        by = ring_y[b];
        ax = ax - px;
        ay = ay - py;
        bx = bx - px;
        by = by - py;
        return ax * by - ay * bx;
    endfunction

    function automatic bit point_inside(longint px, longint py);
        int     n, j, k;
        longint c0, c1;
        n = cfg_count;
        if (n > RING)
            n = RING;           // count above capacity walks the full store
        if (!cfg_closed || n < MIN_VERTICES)
            return 1'b0;
        if (!box_set || px < box_lo_x || px > box_hi_x || py < box_lo_y || py > box_hi_y)
            return 1'b0;
        // a zero product never breaks the test, only strictly opposite signs
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 < n) ? i + 1 : 0;
            k  = (j + 1 < n) ? j + 1 : 0;
            c0 = ring_cross(i, j, px, py);
            c1 = ring_cross(j, k, px, py);
            if ((c0 < 0 && c1 > 0) || (c0 > 0 && c1 < 0))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic apply_item(poly_item_t it);
        logic signed [CW-1:0] x, y;
        x = it.x;
        y = it.y;
        case (it.op)
            OP_CLEAR: begin
                box_lo_x = COORD_TOP;
                box_lo_y = COORD_TOP;
                box_hi_x = COORD_BOTTOM;
                box_hi_y = COORD_BOTTOM;
                box_set  = 1'b0;
            end
            OP_LOAD: begin
                // loads widen the box whatever the closed flag says
                ring_x[it.slot] = x;
                ring_y[it.slot] = y;
                if (x < box_lo_x) box_lo_x = x;
                if (x > box_hi_x) box_hi_x = x;
                if (y < box_lo_y) box_lo_y = y;
                if (y > box_hi_y) box_hi_y = y;
                box_set = 1'b1;
            end
            OP_QUERY: begin
                inside_expected.push_back(point_inside(x, y));
            end
            default: ;          // unused operation: no state change, no result
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver and receiver: inputs change on the falling edge only.
    // ------------------------------------------------------------------
    poly_item_t send_q [$];
    poly_item_t drive_item;
    bit         s_took  = 1'b0;     // input handshake seen at the last rising edge
    bit         m_fire  = 1'b0;
    bit         m_quiet = 1'b0;
    int         s_gap   = 0;
    int         m_wait  = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            // channel is free: wait out the gap, then present the next item
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                drive_item = send_q.pop_front();
                s_operation    <= drive_item.op;
                s_vertex_index <= drive_item.slot;
                s_x_coord      <= drive_item.x;
                s_y_coord      <= drive_item.y;
                s_valid        <= 1'b1;
                s_gap   = drive_item.s_quiet ? 0 : $urandom_range(0, MAX_WAIT);
                m_quiet = drive_item.m_quiet;
            end else begin
                s_valid <= 1'b0;
            end
        end
        // receiver stall, counted down per result item
        if (m_wait > 0) begin
            m_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor, scoreboard and watchdog, all on the rising edge.
    // ------------------------------------------------------------------
    int fail_count  = 0;
    int idle_cycles = 0;
    bit inside_want;

    always @(posedge aclk) begin
        s_took = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_took)
            apply_item(drive_item);
        if (m_fire) begin
            if (inside_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result item, inside_res=%0b",
                             $time, m_inside_res);
            end else begin
                inside_want = inside_expected.pop_front();
                if (m_inside_res !== inside_want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: inside_res mismatch, expected %0b, got %0b",
                                 $time, inside_want, m_inside_res);
                end
            end
            m_wait = m_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (!aresetn || s_took || m_fire || (psel && penable && pwrite && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    bit gen_s_quiet = 1'b0;
    bit gen_m_quiet = 1'b0;
    bit slot_written [RING];
    int item_total  = 0;        // items that do something (operation 3 excluded)

    // shadow of the polygon last loaded, used to aim queries
    int poly_x [RING];
    int poly_y [RING];
    int poly_lo_x, poly_hi_x, poly_lo_y, poly_hi_y;

    task automatic push_item(logic [OP_W-1:0] op, int slot, int x, int y);
        poly_item_t it;
        it.op      = op;
        it.slot    = slot[INDEX_W-1:0];
        it.x       = x[CW-1:0];
        it.y       = y[CW-1:0];
        it.s_quiet = gen_s_quiet;
        it.m_quiet = gen_m_quiet;
        send_q.push_back(it);
        if (op == OP_LOAD)
            slot_written[slot[INDEX_W-1:0]] = 1'b1;
        if (op != OP_NOP)
            item_total++;
    endtask

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int to_coord(real v);
        if (v > 32767.0)
            return 32767;
        if (v < -32768.0)
            return -32768;
        return $rtoi(v);
    endfunction

    // waits until every item is taken and every result is back, then lets
    // a query that might still run finish before the caller goes on
    task automatic drain();
        do
            @(posedge aclk);
        while (send_q.size() != 0 || s_valid || inside_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic reg_sel, logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (reg_sel == REG_VERTEX_COUNT)
            cfg_count = value[COUNT_W-1:0];
        else
            cfg_closed = value[0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int count, bit closed);
        drain();
        write_reg(REG_VERTEX_COUNT, count);
        write_reg(REG_CLOSED_FLAG, closed);
    endtask

    // m vertices on a circle at sorted random angles, either orientation;
    // clamping at the coordinate range may bend a few of them
    task automatic load_polygon(int m);
        int  w [RING];
        int  total, acc;
        real r, cx, cy, a0, dir, a;
        total = 0;
        for (int k = 0; k < m; k++) begin
            w[k]  = $urandom_range(1, 64);
            total += w[k];
        end
        case ($urandom_range(0, 9))
            0:          r = 0.0;
            1, 2, 3, 4: r = $urandom_range(3, 300);
            5, 6, 7, 8: r = $urandom_range(300, 8000);
            default:    r = $urandom_range(8000, 46000);
        endcase
        cx  = rand_between(-25000, 25000);
        cy  = rand_between(-25000, 25000);
        a0  = $urandom_range(0, 359) * PI / 180.0;
        dir = $urandom_range(0, 1) ? 1.0 : -1.0;
        acc = 0;
        poly_lo_x = 32767;
        poly_hi_x = -32768;
        poly_lo_y = 32767;
        poly_hi_y = -32768;
        for (int k = 0; k < m; k++) begin
            a   = a0 + dir * (2.0 * PI * acc) / total;
            acc += w[k];
            poly_x[k] = to_coord(cx + r * $cos(a));
            poly_y[k] = to_coord(cy + r * $sin(a));
            if (poly_x[k] < poly_lo_x) poly_lo_x = poly_x[k];
            if (poly_x[k] > poly_hi_x) poly_hi_x = poly_x[k];
            if (poly_y[k] < poly_lo_y) poly_lo_y = poly_y[k];
            if (poly_y[k] > poly_hi_y) poly_hi_y = poly_y[k];
            push_item(OP_LOAD, k, poly_x[k], poly_y[k]);
        end
    endtask

    // query aimed at the polygon: on or next to vertices, on edges, inside, just
    // outside the box, or anywhere
    task automatic query_near_polygon(int m);
        int k, sx, sy, qx, qy;
        k = $urandom_range(0, m - 1);
        case ($urandom_range(0, 7))
            0: begin
                qx = poly_x[k];
                qy = poly_y[k];
            end
            1: begin
                qx = (poly_x[k] + poly_x[(k + 1) % m]) / 2;
                qy = (poly_y[k] + poly_y[(k + 1) % m]) / 2;
            end
            2: begin
                sx = 0;
                sy = 0;
                for (int i = 0; i < m; i++) begin
                    sx += poly_x[i];
                    sy += poly_y[i];
                end
                qx = sx / m;
                qy = sy / m;
            end
            3, 4: begin
                qx = rand_between(poly_lo_x, poly_hi_x);
                qy = rand_between(poly_lo_y, poly_hi_y);
            end
            5: begin
                // one step past a side of the box
                qx = rand_between(poly_lo_x, poly_hi_x);
                qy = rand_between(poly_lo_y, poly_hi_y);
                case ($urandom_range(0, 3))
                    0:       qx = poly_lo_x - 1;
                    1:       qx = poly_hi_x + 1;
                    2:       qy = poly_lo_y - 1;
                    default: qy = poly_hi_y + 1;
                endcase
            end
            6: begin
                qx = poly_x[k] + rand_between(-1, 1);
                qy = poly_y[k] + rand_between(-1, 1);
            end
            default: begin
                qx = $urandom;
                qy = $urandom;
            end
        endcase
        push_item(OP_QUERY, $urandom_range(0, RING - 1), qx, qy);
    endtask

    // random operations, broken load sequences and ignored items
    task automatic noise_burst();
        int len;
        len = rand_between(3, 12);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       push_item(OP_CLEAR, $urandom_range(0, 15), $urandom, $urandom);
                1, 2, 3: push_item(OP_LOAD, $urandom_range(0, 15), $urandom, $urandom);
                4:       push_item(OP_LOAD, $urandom_range(0, 15),
                                   rand_between(-300, 300), rand_between(-300, 300));
                5, 6:    push_item(OP_QUERY, $urandom_range(0, 15), $urandom, $urandom);
                7:       push_item(OP_QUERY, $urandom_range(0, 15),
                                   rand_between(-400, 400), rand_between(-400, 400));
                8:       push_item(OP_NOP, $urandom_range(0, 15), $urandom, $urandom);
                default: begin
                    // clear, then a ring cut short
                    push_item(OP_CLEAR, 0, 0, 0);
                    for (int i = 0; i < rand_between(1, 2); i++)
                        push_item(OP_LOAD, i, rand_between(-500, 500),
                                  rand_between(-500, 500));
                end
            endcase
        end
    endtask

    initial begin
        int n, m, target, start_total, count;
        bit closed;

        for (int k = 0; k < RING; k++)
            slot_written[k] = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --------------------------------------------------------------
        // Directed part. Registers hold their reset values (no vertices,
        // open polyline, box empty).
        // --------------------------------------------------------------
        push_item(OP_QUERY, 0, 0, 0);                   // empty box, open
        push_item(OP_NOP, 15, -1, -1);                  // ignored, no result
        // full-range square, widest possible cross products
        push_item(OP_LOAD, 0, -32768, -32768);
        push_item(OP_LOAD, 1, 32767, -32768);
        push_item(OP_LOAD, 2, 32767, 32767);
        push_item(OP_LOAD, 3, -32768, 32767);
        push_item(OP_QUERY, 15, 32767, 32767);          // open polyline answers 0

        set_config(4, 1'b1);
        push_item(OP_QUERY, 0, -32768, -32768);         // on a corner
        push_item(OP_QUERY, 15, 32767, 32767);
        push_item(OP_QUERY, 0, 0, 0);                   // center
        push_item(OP_CLEAR, 15, -1, -1);
        push_item(OP_QUERY, 0, 0, 0);                   // box empty again
        push_item(OP_LOAD, 0, -32768, -32768);          // box shrinks to one point
        push_item(OP_QUERY, 0, 0, 0);                   // outside the box
        push_item(OP_QUERY, 0, -32768, -32768);         // the box point itself
        // small diamond: in the box but outside the ring, then on an edge
        push_item(OP_CLEAR, 0, 0, 0);
        push_item(OP_LOAD, 0, 0, -100);
        push_item(OP_LOAD, 1, 100, 0);
        push_item(OP_LOAD, 2, 0, 100);
        push_item(OP_LOAD, 3, -100, 0);
        push_item(OP_QUERY, 0, 90, 90);                 // opposite signs
        push_item(OP_QUERY, 0, 50, 50);                 // zero product on an edge

        set_config(2, 1'b1);
        push_item(OP_QUERY, 0, 0, 0);                   // too few vertices

        // --------------------------------------------------------------
        // Random part, one register setting per phase. Every phase
        // starts from an idle core.
        // --------------------------------------------------------------
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin count = 16; closed = 1'b1; end
                1:       begin count = 3;  closed = 1'b1; end
                2:       begin count = 31; closed = 1'b1; end
                3:       begin count = 0;  closed = 1'b1; end
                4:       begin count = rand_between(4, 15);  closed = 1'b1; end
                5:       begin count = rand_between(17, 30); closed = 1'b1; end
                6:       begin count = 16; closed = 1'b0; end
                default: begin count = rand_between(3, 16);  closed = 1'b1; end
            endcase
            set_config(count, closed);

            n = (count > RING) ? RING : count;
            // the ring walk only ever reads slots that hold a vertex
            for (int k = 0; k < n; k++)
                if (!slot_written[k])
                    push_item(OP_LOAD, k, $urandom, $urandom);

            // settings where every query answers 0 get a shorter phase
            target      = (closed && n >= MIN_VERTICES) ? 200 : 75;
            start_total = item_total;
            while (item_total - start_total < target) begin
                gen_s_quiet = ($urandom_range(0, 4) == 0);
                gen_m_quiet = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) < 7) begin
                    m = (n >= MIN_VERTICES) ? n : rand_between(MIN_VERTICES, RING);
                    // now and then the new ring adds to the old box
                    if ($urandom_range(0, 4) != 0)
                        push_item(OP_CLEAR, $urandom_range(0, 15), $urandom, $urandom);
                    load_polygon(m);
                    repeat (rand_between(4, 10)) query_near_polygon(m);
                end else begin
                    noise_burst();
                end
            end
        end

        drain();
        if (fail_count == 0 && inside_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
